[src/rkmd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkmd_pkg
// Shared widths, zone thresholds and types for the knob motion decoder.
// ----------------------------------------------------------------------------
package rkmd_pkg;

  // field widths
  localparam int SAMPLE_W   = 10;
  localparam int DELTA_W    = 10;
  localparam int AVG_W      = 18;
  localparam int GAIN_W     = 16;
  localparam int ADJ_W      = 24;
  localparam int PROD_W     = AVG_W + GAIN_W;
  localparam int SHIFT_W    = PROD_W - 8;
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 56;

  // track zones, in converter counts
  localparam logic [SAMPLE_W-1:0] LOW_EDGE  = 10'd30;
  localparam logic [SAMPLE_W-1:0] LOW_ZONE  = 10'd68;
  localparam logic [SAMPLE_W-1:0] GAP_MID   = 10'd480;
  localparam logic [SAMPLE_W-1:0] HIGH_ZONE = 10'd956;
  localparam logic [SAMPLE_W-1:0] HIGH_EDGE = 10'd980;

  // movement limits
  localparam logic signed [SAMPLE_W:0]  JUMP_LIMIT = 11'sd400;
  localparam logic signed [DELTA_W-1:0] EDGE_STEP  = 10'sd6;
  localparam logic signed [AVG_W:0]     AVG_LIMIT  = 19'sd102400;

  // reset gain, 1.0 in Q8.8
  localparam logic signed [GAIN_W-1:0] GAIN_RESET = 16'sd256;

  // decoded movement and new average for one transaction
  typedef struct packed {
    logic signed [DELTA_W-1:0] delta;
    logic signed [AVG_W-1:0]   avg;
  } rkmd_move_t;

endpackage

[src/rkmd_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkmd_decode
// Zone decode of one sample against the two-entry history, plus the
// movement average update. Holds the decoder state and the stage register.
// ----------------------------------------------------------------------------
module rkmd_decode (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s0_vld,
  input  logic [rkmd_pkg::SAMPLE_W-1:0] s0_sample,
  output logic                          s0_ld,
  output logic                          s1_vld,
  output rkmd_pkg::rkmd_move_t          s1_move,
  input  logic                          s1_ld
);

  logic [rkmd_pkg::SAMPLE_W-1:0]      hist_recent_r;
  logic [rkmd_pkg::SAMPLE_W-1:0]      hist_older_r;
  logic                               primed_r;
  logic signed [rkmd_pkg::AVG_W-1:0]  avg_move_r;
  logic                               s1_vld_r;
  rkmd_pkg::rkmd_move_t               s1_move_r;

  logic                               adv;
  logic [rkmd_pkg::SAMPLE_W-1:0]      now;
  logic [rkmd_pkg::SAMPLE_W-1:0]      a;
  logic [rkmd_pkg::SAMPLE_W-1:0]      b;
  logic [rkmd_pkg::SAMPLE_W-1:0]      a_adj;
  logic [rkmd_pkg::SAMPLE_W-1:0]      older_nxt;
  logic signed [rkmd_pkg::SAMPLE_W:0] diff;
  logic signed [rkmd_pkg::DELTA_W-1:0] delta;
  logic signed [rkmd_pkg::AVG_W-1:0]  val;
  logic signed [rkmd_pkg::AVG_W:0]    gap;
  logic signed [rkmd_pkg::AVG_W:0]    abs_gap;
  logic signed [rkmd_pkg::AVG_W:0]    abs_val;
  logic signed [rkmd_pkg::AVG_W:0]    abs_ave;
  logic signed [rkmd_pkg::AVG_W:0]    sum;
  logic signed [rkmd_pkg::AVG_W-1:0]  avg_move_nxt;

  // stage moves when empty or when the next stage takes its transaction
  assign s0_ld   = !s1_vld_r || s1_ld;
  assign adv     = s0_vld && s0_ld;
  assign s1_vld  = s1_vld_r;
  assign s1_move = s1_move_r;

  // history as seen by this sample: the first sample fills both entries
  assign now = s0_sample;
  assign a   = primed_r ? hist_recent_r : now;
  assign b   = primed_r ? hist_older_r  : now;

  // reject readings that contradict a crossing of the gap
  always_comb begin
    a_adj = a;
    priority if (a < rkmd_pkg::GAP_MID && b > rkmd_pkg::GAP_MID) begin
      if (now < a) a_adj = now;
    end else if (a > rkmd_pkg::GAP_MID && b < rkmd_pkg::GAP_MID) begin
      if (now > a) a_adj = now;
    end else if (now > rkmd_pkg::GAP_MID && a < rkmd_pkg::GAP_MID &&
                 b < rkmd_pkg::GAP_MID) begin
      if (a > b) a_adj = b;
    end else if (now < rkmd_pkg::GAP_MID && a > rkmd_pkg::GAP_MID &&
                 b > rkmd_pkg::GAP_MID) begin
      if (a < b) a_adj = b;
    end else begin
      a_adj = a;
    end
  end

  assign diff = $signed({1'b0, a_adj}) - $signed({1'b0, b});

  // zone rules; every decoded step stays within the jump limit, so the
  // wrap into the signed ten-bit range of -512 to 511 never changes the result
  always_comb begin
    delta     = '0;
    older_nxt = b;
    priority if (a < rkmd_pkg::LOW_EDGE) begin
      if (b >= rkmd_pkg::LOW_ZONE && b < rkmd_pkg::GAP_MID) delta = -rkmd_pkg::EDGE_STEP;
      else if (b >= rkmd_pkg::GAP_MID) delta = rkmd_pkg::EDGE_STEP;
      older_nxt = a;
    end else if (a < rkmd_pkg::LOW_ZONE) begin
      older_nxt = b;
    end else if (b < rkmd_pkg::LOW_EDGE) begin
      if (a < rkmd_pkg::GAP_MID) begin
        delta     = rkmd_pkg::EDGE_STEP;
        older_nxt = a;
      end else begin
        delta     = -rkmd_pkg::EDGE_STEP;
        older_nxt = (now < a) ? a : now;
      end
    end else if (a > rkmd_pkg::HIGH_EDGE) begin
      if (b <= rkmd_pkg::HIGH_ZONE && b > rkmd_pkg::GAP_MID) delta = rkmd_pkg::EDGE_STEP;
      else if (b <= rkmd_pkg::GAP_MID) delta = -rkmd_pkg::EDGE_STEP;
      older_nxt = a;
    end else if (a > rkmd_pkg::HIGH_ZONE) begin
      older_nxt = b;
    end else if (b > rkmd_pkg::HIGH_EDGE) begin
      if (a > rkmd_pkg::GAP_MID) begin
        delta     = -rkmd_pkg::EDGE_STEP;
        older_nxt = a;
      end else begin
        delta     = rkmd_pkg::EDGE_STEP;
        older_nxt = (now > a) ? a : now;
      end
    end else begin
      // mid track: plain difference, drop large jumps
      if (diff > rkmd_pkg::JUMP_LIMIT || diff < -rkmd_pkg::JUMP_LIMIT) delta = '0;
      else delta = diff[rkmd_pkg::DELTA_W-1:0];
      older_nxt = a_adj;
    end
  end

  // average in the new movement when it is close or smaller, else hold
  assign val     = {delta, 8'd0};
  assign gap     = $signed({avg_move_r[rkmd_pkg::AVG_W-1], avg_move_r}) -
                   $signed({val[rkmd_pkg::AVG_W-1], val});
  assign abs_gap = gap[rkmd_pkg::AVG_W] ? -gap : gap;
  assign abs_val = val[rkmd_pkg::AVG_W-1] ? -$signed({val[rkmd_pkg::AVG_W-1], val})
                                          :  $signed({val[rkmd_pkg::AVG_W-1], val});
  assign abs_ave = avg_move_r[rkmd_pkg::AVG_W-1]
                   ? -$signed({avg_move_r[rkmd_pkg::AVG_W-1], avg_move_r})
                   :  $signed({avg_move_r[rkmd_pkg::AVG_W-1], avg_move_r});
  assign sum     = $signed({avg_move_r[rkmd_pkg::AVG_W-1], avg_move_r}) +
                   $signed({val[rkmd_pkg::AVG_W-1], val});

  always_comb begin
    if (abs_gap < rkmd_pkg::AVG_LIMIT || abs_val < abs_ave) begin
      avg_move_nxt = sum[rkmd_pkg::AVG_W:1];
    end else begin
      avg_move_nxt = avg_move_r;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_recent_r <= '0;
      hist_older_r  <= '0;
      primed_r      <= 1'b0;
      avg_move_r    <= '0;
    end else if (adv) begin
      hist_recent_r <= now;
      hist_older_r  <= older_nxt;
      primed_r      <= 1'b1;
      avg_move_r    <= avg_move_nxt;
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s0_ld) begin
      s1_vld_r <= s0_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_move_r.delta <= delta;
      s1_move_r.avg   <= avg_move_nxt;
    end
  end

  // once primed, stay primed until reset
  a_primed_holds: assert property (@(posedge clk) disable iff (!rst_n)
    primed_r |=> primed_r)
    else $error("primed flag dropped");

  // state changes only when a transaction leaves the input stage
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(avg_move_r) && $stable(hist_recent_r) && $stable(hist_older_r))
    else $error("decoder state changed without a transaction");

  // decoded movement stays within the jump limit
  a_delta_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> (s1_move_r.delta <= 10'sd400 && s1_move_r.delta >= -10'sd400))
    else $error("knob movement out of range");

  // stage register carries the average that the state took
  a_avg_match: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> s1_move_r.avg == avg_move_r)
    else $error("stage average differs from state");

endmodule

[src/rkmd_scale.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkmd_scale
// Multiplies the average by the Q8.8 gain, scales back to Q.8 and
// saturates into the output register.
// ----------------------------------------------------------------------------
module rkmd_scale (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [rkmd_pkg::GAIN_W-1:0]  gain,
  input  logic                                s1_vld,
  input  rkmd_pkg::rkmd_move_t                s1_move,
  output logic                                s1_ld,
  output logic                                out_vld,
  output logic [rkmd_pkg::OUT_TDATA_W-1:0]    out_data,
  input  logic                                out_rdy
);

  logic                                 s2_vld_r;
  rkmd_pkg::rkmd_move_t                 s2_move_r;
  logic signed [rkmd_pkg::PROD_W-1:0]   prod_r;
  logic                                 out_vld_r;
  logic [rkmd_pkg::OUT_TDATA_W-1:0]     out_data_r;

  logic                                 out_ld;
  logic                                 s2_ld;
  logic signed [rkmd_pkg::SHIFT_W-1:0]  shifted;
  logic signed [rkmd_pkg::ADJ_W-1:0]    adj;
  logic                                 fits;

  // ready chain back from the output register
  assign out_ld  = !out_vld_r || out_rdy;
  assign s2_ld   = !s2_vld_r || out_ld;
  assign s1_ld   = s2_ld;
  assign out_vld = out_vld_r;
  assign out_data = out_data_r;

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_ld) begin
      s2_vld_r <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ld && s1_vld) begin
      s2_move_r <= s1_move;
      prod_r    <= rkmd_pkg::PROD_W'(s1_move.avg) * rkmd_pkg::PROD_W'(gain);
    end
  end

  // drop the eight fraction bits of the gain (floor), then saturate
  assign shifted = prod_r[rkmd_pkg::PROD_W-1:8];
  assign fits    = (shifted[rkmd_pkg::SHIFT_W-1:rkmd_pkg::ADJ_W-1] == '0) ||
                   (shifted[rkmd_pkg::SHIFT_W-1:rkmd_pkg::ADJ_W-1] == '1);

  always_comb begin
    if (fits) begin
      adj = shifted[rkmd_pkg::ADJ_W-1:0];
    end else if (shifted[rkmd_pkg::SHIFT_W-1]) begin
      adj = {1'b1, {(rkmd_pkg::ADJ_W-1){1'b0}}};
    end else begin
      adj = {1'b0, {(rkmd_pkg::ADJ_W-1){1'b1}}};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_ld) begin
      out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld && s2_vld_r) begin
      out_data_r <= {4'd0, adj, s2_move_r.avg, s2_move_r.delta};
    end
  end

  // a full product stage waiting on a stalled output is not overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r && !out_ld |=> s2_vld_r && $stable(prod_r))
    else $error("product stage overwritten while stalled");

  // output register loads only from a valid product stage
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_ld && !s2_vld_r |=> !out_vld_r)
    else $error("result presented without a source");

  // pad bits of the result stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_data_r[rkmd_pkg::OUT_TDATA_W-1:52] == 4'd0)
    else $error("result pad bits set");

endmodule

[src/resolver_knob_motion_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resolver_knob_motion_decoder
// Decodes samples of a continuous-rotation knob potentiometer into a
// movement, a filtered average and a gain-scaled adjustment.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per converter sample, in_tdata[9:0] = sample.
//   out_* : one transaction per sample, in order: knob_delta, the updated
//           delta_average (Q.8) and adjustment = delta_average * gain (Q.8,
//           saturated to 24 bits).
//   cfg_* : cfg_we writes the Q8.8 gain from cfg_wdata; write only while no
//           transaction is in flight. Reset gain is 1.0.
// Timing: four register stages (input, decode, product, output). A sample
//   accepted into the input register passes the decode and product stages
//   to the output register. One sample per cycle is taken in steady state while
//   out_tready is high; the decoder state (history, average) closes its loop inside the decode stage.
// Reset: history and average clear, the first sample after reset primes
//   the history and yields a zero movement.
// Stall: when out_tready is low, transactions keep entering until the decode,
//   product and output stages are full; in_tready then drops until the output is taken.
// ----------------------------------------------------------------------------
module resolver_knob_motion_decoder (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rkmd_pkg::IN_TDATA_W-1:0]     in_tdata,   // [9:0] sample
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rkmd_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [9:0] knob_delta,
                                                          // [27:10] delta_average,
                                                          // [51:28] adjustment
  // configuration
  input  logic                                cfg_we,
  input  logic [rkmd_pkg::GAIN_W-1:0]         cfg_wdata   // gain, Q8.8 signed
);

  logic                                 s0_vld_r;
  logic [rkmd_pkg::SAMPLE_W-1:0]        s0_sample_r;
  logic signed [rkmd_pkg::GAIN_W-1:0]   gain_r;

  logic                                 s0_ld;
  logic                                 s1_vld;
  rkmd_pkg::rkmd_move_t                 s1_move;
  logic                                 s1_ld;

  assign in_tready = s0_ld;

  // gain register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= rkmd_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      gain_r <= $signed(cfg_wdata);
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (s0_ld) begin
      s0_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && s0_ld) begin
      s0_sample_r <= in_tdata[rkmd_pkg::SAMPLE_W-1:0];
    end
  end

  rkmd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .s0_vld    (s0_vld_r),
    .s0_sample (s0_sample_r),
    .s0_ld     (s0_ld),
    .s1_vld    (s1_vld),
    .s1_move   (s1_move),
    .s1_ld     (s1_ld)
  );

  rkmd_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .gain     (gain_r),
    .s1_vld   (s1_vld),
    .s1_move  (s1_move),
    .s1_ld    (s1_ld),
    .out_vld  (out_tvalid),
    .out_data (out_tdata),
    .out_rdy  (out_tready)
  );

endmodule
